@@ rtl/core/bleadv_pkg.sv @@
// ----------------------------------------------------------------------------
// bleadv_pkg
// Shared types and constants of the advertising-data record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package bleadv_pkg;

  // Default cap on kept name bytes
  localparam int unsigned NameMaxDefault = 16;

  // AD type codes of interest
  localparam logic [7:0] AdTypeNameFull  = 8'h09;
  localparam logic [7:0] AdTypeNameShort = 8'h08;
  localparam logic [7:0] AdTypeMaker     = 8'hFF;
  localparam logic [7:0] AdTypeSvc16     = 8'h16;

  // 16-bit service UUID 0x180A, little-endian on air
  localparam logic [7:0] SvcUuidLo = 8'h0A;
  localparam logic [7:0] SvcUuidHi = 8'h18;

  // Minimum data bytes for a field to be decoded
  localparam logic [7:0] MakerMinLen = 8'd7;
  localparam logic [7:0] SvcMinLen   = 8'd10;

  // Walker phase, one-hot
  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_TYPE = 4'b0010,
    PH_DATA = 4'b0100,
    PH_STOP = 4'b1000
  } phase_e;

  // Field being collected
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_MAKER = 2'd2,
    KIND_SVC   = 2'd3
  } kind_e;

  // Result codes
  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_NONE    = 2'd1,
    RES_TRUNC   = 2'd2,
    RES_PARTIAL = 2'd3
  } res_code_e;

  // Decoded record handed from the walker to the emitter
  typedef struct packed {
    res_code_e   code;
    logic [1:0]  found;
    logic [63:0] id_time;   // id in low word, firmware time in high word
    logic [39:0] maker;     // manufacturer bytes 2..6, byte 2 lowest
  } record_t;

endpackage

`default_nettype wire

@@ rtl/core/bleadv_parse.sv @@
// ----------------------------------------------------------------------------
// bleadv_parse
// Length-type-value walker: updates field state on every accepted byte and
// presents the finished record on the final byte of a payload.
// ----------------------------------------------------------------------------
`default_nettype none

module bleadv_parse
  import bleadv_pkg::*;
#(
  parameter int unsigned NAME_MAX = NameMaxDefault,
  localparam int unsigned CntW = $clog2(NAME_MAX + 1),
  localparam int unsigned IdxW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic [7:0]                   adv_byte_i,
  input  wire logic                         last_byte_i,
  input  wire logic                         require_full_i,
  output logic                              snap_valid_o,
  output record_t                           record_o,
  output logic [CntW-1:0]                   name_count_o,
  output logic [NAME_MAX-1:0][7:0]          name_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  left_q, left_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  pos_q, pos_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [39:0] mkp_q, mkp_d, mkk_q, mkk_d;
  logic        mkv_q, mkv_d;
  logic [63:0] idp_q, idp_d, idk_q, idk_d;
  logic [1:0]  flags_q, flags_d;   // bit0 identity, bit1 relevant seen
  logic        finish;
  logic        name_we;
  logic [NAME_MAX-1:0][7:0] name_q, name_next;
  logic        trunc;
  logic [1:0]  found;

  // Per-byte field state update
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    kind_d  = kind_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    done_d  = done_q;
    mkp_d   = mkp_q;
    mkk_d   = mkk_q;
    mkv_d   = mkv_q;
    idp_d   = idp_q;
    idk_d   = idk_q;
    flags_d = flags_q;
    finish  = 1'b0;
    name_we = 1'b0;
    if (accept_i) begin
      case (phase_q)
        PH_LEN: begin
          if (adv_byte_i == 8'd0) begin
            phase_d = PH_STOP;
          end else begin
            left_d  = adv_byte_i;
            phase_d = PH_TYPE;
          end
        end
        PH_TYPE: begin
          pos_d  = 8'd0;
          kind_d = KIND_NONE;
          if ((adv_byte_i == AdTypeNameFull || adv_byte_i == AdTypeNameShort) && !done_q) begin
            kind_d     = KIND_NAME;
            flags_d[1] = 1'b1;
          end else if (adv_byte_i == AdTypeMaker) begin
            kind_d     = KIND_MAKER;
            mkp_d      = '0;
            flags_d[1] = 1'b1;
          end else if (adv_byte_i == AdTypeSvc16) begin
            kind_d = KIND_SVC;
            idp_d  = '0;
          end
          left_d = left_q - 8'd1;
          if (left_d == 8'd0) begin
            finish = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          case (kind_q)
            KIND_NAME: begin
              // name stops at the first zero byte
              if ({{(8-CntW){1'b0}}, cnt_q} == pos_q && adv_byte_i != 8'd0 &&
                  cnt_q < CntW'(NAME_MAX)) begin
                name_we = 1'b1;
                cnt_d   = cnt_q + CntW'(1);
                done_d  = 1'b1;
              end
            end
            KIND_MAKER: begin
              for (int i = 0; i < 5; i++) begin
                if (pos_q == 8'(i + 2)) mkp_d[i*8 +: 8] = adv_byte_i;
              end
            end
            KIND_SVC: begin
              if ((pos_q == 8'd0 && adv_byte_i != SvcUuidLo) ||
                  (pos_q == 8'd1 && adv_byte_i != SvcUuidHi)) begin
                kind_d = KIND_NONE;
              end else begin
                for (int i = 0; i < 8; i++) begin
                  if (pos_q == 8'(i + 2)) idp_d[i*8 +: 8] = adv_byte_i;
                end
              end
            end
            default: ;
          endcase
          if (pos_q != 8'hFF) pos_d = pos_q + 8'd1;
          left_d = left_q - 8'd1;
          if (left_d == 8'd0) finish = 1'b1;
        end
        default: ;
      endcase

      // Field complete: commit what it decoded
      if (finish) begin
        if (kind_d == KIND_MAKER) begin
          if (pos_d >= MakerMinLen) begin
            mkk_d = mkp_d;
            mkv_d = 1'b1;
          end else begin
            mkv_d = 1'b0;
          end
        end else if (kind_d == KIND_SVC && pos_d >= SvcMinLen) begin
          idk_d   = idp_d;
          flags_d = {1'b1, |idp_d[31:0]};
        end
        kind_d  = KIND_NONE;
        phase_d = PH_LEN;
      end
    end
  end

  // Name store with this byte's write folded in
  always_comb begin
    name_next = name_q;
    if (name_we) name_next[cnt_q[IdxW-1:0]] = adv_byte_i;
  end

  // Record seen on the final byte
  assign trunc = (phase_d == PH_TYPE) || (phase_d == PH_DATA);
  assign found = {mkv_d, flags_d[0]};

  always_comb begin
    record_o     = '0;
    name_count_o = '0;
    if (trunc) begin
      record_o.code = RES_TRUNC;
    end else begin
      if (!flags_d[1]) begin
        record_o.code = RES_NONE;
      end else if (require_full_i && found != 2'b11) begin
        record_o.code = RES_PARTIAL;
      end else begin
        record_o.code = RES_OK;
      end
      record_o.found   = found;
      record_o.id_time = idk_d;
      record_o.maker   = mkv_d ? mkk_d : '0;
      name_count_o     = cnt_d;
    end
  end

  assign snap_valid_o = accept_i && last_byte_i;
  assign name_o       = name_next;

  // Control and decoded state; cleared after each payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN;
      left_q  <= '0;
      kind_q  <= KIND_NONE;
      pos_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      mkp_q   <= '0;
      mkk_q   <= '0;
      mkv_q   <= 1'b0;
      idp_q   <= '0;
      idk_q   <= '0;
      flags_q <= '0;
    end else if (accept_i && last_byte_i) begin
      phase_q <= PH_LEN;
      left_q  <= '0;
      kind_q  <= KIND_NONE;
      pos_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      mkp_q   <= '0;
      mkk_q   <= '0;
      mkv_q   <= 1'b0;
      idp_q   <= '0;
      idk_q   <= '0;
      flags_q <= '0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      kind_q  <= kind_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      mkp_q   <= mkp_d;
      mkk_q   <= mkk_d;
      mkv_q   <= mkv_d;
      idp_q   <= idp_d;
      idk_q   <= idk_d;
      flags_q <= flags_d;
    end
  end

  // Name bytes, valid only below the count
  always_ff @(posedge clk_i) begin
    if (name_we) name_q[cnt_q[IdxW-1:0]] <= adv_byte_i;
  end

endmodule

`default_nettype wire

@@ rtl/core/ble_adv_record_parser_top.sv @@
// ----------------------------------------------------------------------------
// ble_adv_record_parser_top
// Advertising-data record parser: walks AD fields byte by byte and emits one
// result item per kept name byte (one item if none is kept) when the payload ends.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 content
//  s_axis    in         tvalid/tready, tlast      payload byte, strength
//  m_axis    out        tvalid/tready, tlast      result items, code in tuser
//  cfg       in         cfg_wr_en_i               require_full_record
//
//  One payload byte is taken per cycle unless a final byte stalls; the byte walker needs no wait.
//  A finished payload is copied into a run buffer and drained as max(name length, 1)
//  results into the output register, one per cycle while that register can take it.
//  A final byte stalls only while the run buffer still holds a prior payload.
//  Reset clears walker state, the configuration bit, run buffer valid and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_adv_record_parser_top
  import bleadv_pkg::*;
#(
  parameter int unsigned NAME_MAX = NameMaxDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input items
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [15:0]  s_axis_tdata,   // adv_byte[7:0], signal_strength[15:8]
  input  wire logic         s_axis_tlast,   // last_byte
  // result items
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata,   // strength_out[7:0], name_char[15:8],
                                            // found_flags[17:16], device_id[49:18],
                                            // firmware_time[81:50], led_total[89:82],
                                            // kind_and_color[97:90], motion_state[105:98],
                                            // face_number[113:106], battery_byte[121:114]
  output logic [1:0]        m_axis_tuser,   // result_code
  output logic              m_axis_tlast,   // last_of_run
  // configuration
  input  wire logic         cfg_wr_en_i,
  input  wire logic         cfg_wr_data_i   // require_full_record
);

  localparam int unsigned CntW = $clog2(NAME_MAX + 1);
  localparam int unsigned IdxW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

  logic                     req_full_q;
  logic                     accept;
  logic                     snap_valid;
  record_t                  snap_rec;
  logic [CntW-1:0]          snap_cnt;
  logic [NAME_MAX-1:0][7:0] snap_name;

  // run buffer
  logic                     run_valid_q;
  logic [CntW-1:0]          run_idx_q;
  logic [CntW-1:0]          run_cnt_q;
  record_t                  run_rec_q;
  logic [7:0]               run_str_q;
  logic [NAME_MAX-1:0][7:0] run_name_q;
  logic                     run_last;
  logic                     move;
  logic                     run_free;
  logic [7:0]               run_char;

  // output register
  logic                     out_valid_q;
  record_t                  out_rec_q;
  logic [7:0]               out_str_q;
  logic [7:0]               out_char_q;
  logic                     out_last_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_full_q <= 1'b0;
    end else if (cfg_wr_en_i) begin
      req_full_q <= cfg_wr_data_i;
    end
  end

  // Input side: only a final byte needs a free run buffer
  assign s_axis_tready = !s_axis_tlast || run_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bleadv_parse #(
    .NAME_MAX(NAME_MAX)
  ) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .adv_byte_i    (s_axis_tdata[7:0]),
    .last_byte_i   (s_axis_tlast),
    .require_full_i(req_full_q),
    .snap_valid_o  (snap_valid),
    .record_o      (snap_rec),
    .name_count_o  (snap_cnt),
    .name_o        (snap_name)
  );

  // Run drain: one result per cycle while output register can take it
  assign run_last = ({1'b0, run_idx_q} + {{CntW{1'b0}}, 1'b1}) >= {1'b0, run_cnt_q};
  assign move     = run_valid_q && (!out_valid_q || m_axis_tready);
  assign run_free = !run_valid_q || (move && run_last);
  assign run_char = (run_cnt_q != '0) ? run_name_q[run_idx_q[IdxW-1:0]] : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      run_idx_q   <= '0;
    end else if (snap_valid) begin
      run_valid_q <= 1'b1;
      run_idx_q   <= '0;
    end else if (move) begin
      if (run_last) begin
        run_valid_q <= 1'b0;
      end else begin
        run_idx_q <= run_idx_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_valid) begin
      run_cnt_q  <= snap_cnt;
      run_rec_q  <= snap_rec;
      run_str_q  <= s_axis_tdata[15:8];
      run_name_q <= snap_name;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_rec_q  <= run_rec_q;
      out_str_q  <= run_str_q;
      out_char_q <= run_char;
      out_last_q <= run_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_rec_q.code;
  assign m_axis_tdata  = {6'd0,
                          out_rec_q.maker,
                          out_rec_q.id_time,
                          out_rec_q.found,
                          out_char_q,
                          out_str_q};

endmodule

`default_nettype wire

@@ tb/sv/ble_adv_record_parser_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ble_adv_record_parser_top_tb
// Self-checking bench for the advertising-data record parser. A short
// stimulus table of hand-built payloads comes first. Random payloads made of
// name, manufacturer, service-data, unknown and terminator fields follow, some
// of them cut short and some pure noise. Both stream sides idle at random. A
// behavioral walker predicts every result item that the table does not spell out,
// and the bench compares each output item field by field against the predictions.
// ----------------------------------------------------------------------------

module ble_adv_record_parser_top_tb;
  import bleadv_pkg::*;

  localparam int unsigned NameMax      = NameMaxDefault;
  localparam int          ClkPeriod    = 10;
  localparam int          SettleCycles = 2 * NameMax + 8;
  localparam int          CycleLimit   = 400000;
  localparam int          DirRows      = 30;

  // One result item, as the parser reports it
  typedef struct packed {
    res_code_e   code;
    logic [7:0]  rssi_out;
    logic [7:0]  name_char;
    logic        last_run;
    logic [1:0]  found;
    logic [31:0] dev_id;
    logic [31:0] fw_time;
    logic [7:0]  leds;
    logic [7:0]  kind_color;
    logic [7:0]  motion;
    logic [7:0]  face;
    logic [7:0]  battery;
  } report_t;

  // Directed stimulus rows: one payload byte or one register write
  typedef enum logic {
    ROW_BYTE,
    ROW_CFG
  } row_op_e;

  typedef struct packed {
    row_op_e    op;
    logic [7:0] adv;    // payload byte, or register value in bit 0
    logic       last;
    logic [7:0] rssi;
    logic       typed;  // result spelled out below instead of predicted
    res_code_e  code;
  } row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata;   // adv_byte[7:0], signal_strength[15:8]
  logic         s_axis_tlast;   // last_byte
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // strength_out, name_char, found_flags, device_id,
                                // firmware_time, led_total, kind_and_color,
                                // motion_state, face_number, battery_byte
  logic [1:0]   m_axis_tuser;   // result_code
  logic         m_axis_tlast;   // last_of_run
  logic         cfg_wr_en_i;
  logic         cfg_wr_data_i;

  ble_adv_record_parser_top #(
    .NAME_MAX (NameMax)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  // Walker model state
  phase_e      walk_phase;
  kind_e       walk_kind;
  logic [7:0]  walk_left;
  logic [7:0]  walk_pos;
  logic [7:0]  name_mem [NameMax];
  logic [4:0]  name_len;
  bit          name_done;
  logic [39:0] maker_acc;
  logic [39:0] maker_kept;
  bit          maker_ok;
  logic [63:0] id_acc;
  logic [63:0] id_kept;
  logic [1:0]  seen_flags;      // bit0 identity, bit1 relevant field seen
  bit          need_full;

  report_t     pending_reports [$];
  logic [7:0]  adv_bytes [$];
  row_t        dir_plan [DirRows];
  int          mismatches;
  int          cycle_count;
  bit          send_burst;
  bit          take_burst;

  // Clock
  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("ble_adv_record_parser_top_tb failed");
      $finish;
    end
  end

  task automatic clear_walker();
    walk_phase = PH_LEN;
    walk_kind  = KIND_NONE;
    walk_left  = '0;
    walk_pos   = '0;
    name_len   = '0;
    name_done  = 1'b0;
    maker_acc  = '0;
    maker_kept = '0;
    maker_ok   = 1'b0;
    id_acc     = '0;
    id_kept    = '0;
    seen_flags = '0;
  endtask

  // End of a field: commit manufacturer or service data if long enough
  task automatic close_field();
    if (walk_kind == KIND_MAKER) begin
      if (walk_pos >= MakerMinLen) begin
        maker_kept = maker_acc;
        maker_ok   = 1'b1;
      end else begin
        maker_ok = 1'b0;
      end
    end else if (walk_kind == KIND_SVC && walk_pos >= SvcMinLen) begin
      id_kept    = id_acc;
      seen_flags = {1'b1, id_kept[31:0] != 32'd0};
    end
    walk_kind  = KIND_NONE;
    walk_phase = PH_LEN;
  endtask

  // Walks one accepted byte; on the last byte queues the results it causes
  task automatic parse_adv_byte(input logic [7:0] b, input bit last,
                                input logic [7:0] rssi, input bit keep);
    report_t     rep;
    logic [1:0]  found;
    logic [39:0] mk;
    int          n;
    case (walk_phase)
      PH_LEN: begin
        if (b == 8'h00) begin
          walk_phase = PH_STOP;
        end else begin
          walk_left  = b;
          walk_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        walk_pos  = '0;
        walk_kind = KIND_NONE;
        if ((b == AdTypeNameFull || b == AdTypeNameShort) && !name_done) begin
          walk_kind     = KIND_NAME;
          seen_flags[1] = 1'b1;
        end else if (b == AdTypeMaker) begin
          walk_kind     = KIND_MAKER;
          maker_acc     = '0;
          seen_flags[1] = 1'b1;
        end else if (b == AdTypeSvc16) begin
          walk_kind = KIND_SVC;
          id_acc    = '0;
        end
        walk_left--;
        if (walk_left == 8'd0) close_field();
        else walk_phase = PH_DATA;
      end
      PH_DATA: begin
        case (walk_kind)
          KIND_NAME: begin
            // only a gapless run of nonzero bytes from the start is kept
            if ({3'b000, name_len} == walk_pos && b != 8'h00 && name_len < NameMax) begin
              name_mem[name_len] = b;
              name_len++;
              name_done = 1'b1;
            end
          end
          KIND_MAKER: begin
            if (walk_pos >= 8'd2 && walk_pos <= 8'd6)
              maker_acc[(walk_pos - 2) * 8 +: 8] = b;
          end
          KIND_SVC: begin
            if ((walk_pos == 8'd0 && b != SvcUuidLo) || (walk_pos == 8'd1 && b != SvcUuidHi))
              walk_kind = KIND_NONE;
            else if (walk_pos >= 8'd2 && walk_pos <= 8'd9)
              id_acc[(walk_pos - 2) * 8 +: 8] = b;
          end
          default: ;
        endcase
        if (walk_pos != 8'hFF) walk_pos++;
        walk_left--;
        if (walk_left == 8'd0) close_field();
      end
      default: ;
    endcase

    if (last) begin
      if (walk_phase == PH_TYPE || walk_phase == PH_DATA) begin
        // field left open: one bare truncation item
        rep          = '0;
        rep.code     = RES_TRUNC;
        rep.rssi_out = rssi;
        rep.last_run = 1'b1;
        if (keep) pending_reports.push_back(rep);
      end else begin
        found = {maker_ok, seen_flags[0]};
        mk    = maker_ok ? maker_kept : 40'd0;
        n     = (name_len > 0) ? int'(name_len) : 1;
        for (int k = 0; k < n; k++) begin
          rep = '0;
          if (!seen_flags[1])                rep.code = RES_NONE;
          else if (need_full && found != 2'b11) rep.code = RES_PARTIAL;
          else                                rep.code = RES_OK;
          rep.rssi_out   = rssi;
          rep.name_char  = (name_len > 0) ? name_mem[k] : 8'h00;
          rep.last_run   = (k == n - 1);
          rep.found      = found;
          rep.dev_id     = id_kept[31:0];
          rep.fw_time    = id_kept[63:32];
          rep.leds       = mk[7:0];
          rep.kind_color = mk[15:8];
          rep.motion     = mk[23:16];
          rep.face       = mk[31:24];
          rep.battery    = mk[39:32];
          if (keep) pending_reports.push_back(rep);
        end
      end
      clear_walker();
    end
  endtask

  // Sends one byte after a random gap; called and returns at a falling edge
  task automatic push_byte(input logic [7:0] b, input bit last, input logic [7:0] rssi,
                           input bit typed, input res_code_e code);
    int      gap;
    report_t rep;
    if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rssi, b};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_adv_byte(b, last, rssi, !typed);
    if (typed) begin
      rep          = '0;
      rep.code     = code;
      rep.rssi_out = rssi;
      rep.last_run = 1'b1;
      pending_reports.push_back(rep);
    end
    @(negedge clk_i);
  endtask

  // Register write once the parser has gone quiet
  task automatic set_full_record(input bit value);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    need_full = value;
  endtask

  // Random payloads: mostly well-formed field lists, some noise, some cut short
  task automatic send_payloads(input int n_pay, input int n_min);
    int         sent_pay;
    int         sent_bytes;
    int         mode;
    int         dlen;
    int         cut;
    logic [7:0] ftype;
    logic [7:0] v;
    bit         good_uuid;
    bit         zero_id;
    bit         is_name;
    bit         stop;
    sent_pay   = 0;
    sent_bytes = 0;
    while (sent_pay < n_pay || sent_bytes < n_min) begin
      adv_bytes.delete();
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        repeat ($urandom_range(1, 12)) adv_bytes.push_back(8'($urandom));
      end else begin
        stop = 1'b0;
        repeat ($urandom_range(1, 4)) begin
          if (!stop) begin
            case ($urandom_range(0, 9))
              0, 1, 2: begin
                ftype = $urandom_range(0, 1) ? AdTypeNameFull : AdTypeNameShort;
                dlen  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20)
                                                    : $urandom_range(0, 6);
              end
              3, 4: begin
                ftype = AdTypeMaker;
                dlen  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6)
                                                    : $urandom_range(7, 9);
              end
              5, 6, 7: begin
                ftype = AdTypeSvc16;
                dlen  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9)
                                                    : $urandom_range(10, 12);
              end
              8: begin
                ftype = 8'($urandom);
                dlen  = $urandom_range(0, 4);
              end
              default: begin
                // zero length ends parsing; trailing junk must be ignored
                stop = 1'b1;
                dlen = -1;
              end
            endcase
            if (stop) begin
              adv_bytes.push_back(8'h00);
              repeat ($urandom_range(0, 3)) adv_bytes.push_back(8'($urandom));
            end else begin
              good_uuid = ($urandom_range(0, 4) != 0);
              zero_id   = ($urandom_range(0, 7) == 0);
              is_name   = (ftype == AdTypeNameFull || ftype == AdTypeNameShort);
              adv_bytes.push_back(8'(dlen + 1));
              adv_bytes.push_back(ftype);
              for (int d = 0; d < dlen; d++) begin
                v = 8'($urandom);
                if (ftype == AdTypeSvc16 && good_uuid && d < 2)
                  v = (d == 0) ? SvcUuidLo : SvcUuidHi;
                else if (ftype == AdTypeSvc16 && zero_id && d >= 2 && d < 6)
                  v = 8'h00;
                else if (is_name && $urandom_range(0, 9) == 0)
                  v = 8'h00;
                adv_bytes.push_back(v);
              end
            end
          end
        end
        if ($urandom_range(0, 5) == 0 && adv_bytes.size() > 1) begin
          cut = $urandom_range(1, (adv_bytes.size() > 4) ? 4 : adv_bytes.size() - 1);
          repeat (cut) void'(adv_bytes.pop_back());
        end
      end
      foreach (adv_bytes[i])
        push_byte(adv_bytes[i], i == adv_bytes.size() - 1, 8'($urandom), 1'b0, RES_OK);
      sent_pay++;
      sent_bytes += adv_bytes.size();
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Result side: random stalls, one item per handshake
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    take_burst    = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 19) == 0) take_burst = !take_burst;
      gap = take_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Compare each accepted result item with the oldest prediction
  always @(posedge clk_i) begin : result_mon
    report_t got;
    report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got            = '0;
      got.code       = res_code_e'(m_axis_tuser);
      got.last_run   = m_axis_tlast;
      got.rssi_out   = m_axis_tdata[7:0];
      got.name_char  = m_axis_tdata[15:8];
      got.found      = m_axis_tdata[17:16];
      got.dev_id     = m_axis_tdata[49:18];
      got.fw_time    = m_axis_tdata[81:50];
      got.leds       = m_axis_tdata[89:82];
      got.kind_color = m_axis_tdata[97:90];
      got.motion     = m_axis_tdata[105:98];
      got.face       = m_axis_tdata[113:106];
      got.battery    = m_axis_tdata[121:114];
      if (pending_reports.size() == 0) begin
        $display("%0t: no result expected, got code %0d tdata 0x%0h", $time,
                 m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("result_code", want.code, got.code);
        check_field("strength_out", want.rssi_out, got.rssi_out);
        check_field("name_char", want.name_char, got.name_char);
        check_field("last_of_run", want.last_run, got.last_run);
        check_field("found_flags", want.found, got.found);
        check_field("device_id", want.dev_id, got.dev_id);
        check_field("firmware_time", want.fw_time, got.fw_time);
        check_field("led_total", want.leds, got.leds);
        check_field("kind_and_color", want.kind_color, got.kind_color);
        check_field("motion_state", want.motion, got.motion);
        check_field("face_number", want.face, got.face);
        check_field("battery_byte", want.battery, got.battery);
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = 1'b0;
    mismatches    = 0;
    cycle_count   = 0;
    send_burst    = 1'b0;
    need_full     = 1'b0;
    clear_walker();

    dir_plan = '{
      // lone zero length byte: nothing relevant
      '{ROW_BYTE, 8'h00, 1'b1, 8'h80, 1'b1, RES_NONE},
      // payload ends on a length byte: truncated
      '{ROW_BYTE, 8'h05, 1'b1, 8'h7F, 1'b1, RES_TRUNC},
      // name with a zero byte, then a short name, then stop and junk
      '{ROW_BYTE, 8'h02, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h09, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h00, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h02, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h08, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'hFF, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h00, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h55, 1'b1, 8'h00, 1'b0, RES_OK},
      // ends right after a type byte with data still owed: truncated
      '{ROW_BYTE, 8'h02, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h16, 1'b1, 8'h01, 1'b1, RES_TRUNC},
      '{ROW_CFG,  8'h01, 1'b0, 8'h00, 1'b0, RES_OK},
      // service data with zero id, then a short manufacturer field: incomplete
      '{ROW_BYTE, 8'h0B, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h16, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h0A, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h18, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h00, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h00, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h00, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h00, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'hFF, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'hFF, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'hFF, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'hFF, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h03, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'hFF, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h11, 1'b0, 8'h00, 1'b0, RES_OK},
      '{ROW_BYTE, 8'h22, 1'b1, 8'hFE, 1'b0, RES_OK},
      '{ROW_CFG,  8'h00, 1'b0, 8'h00, 1'b0, RES_OK}
    };

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (dir_plan[i]) begin
      if (dir_plan[i].op == ROW_CFG)
        set_full_record(dir_plan[i].adv[0]);
      else
        push_byte(dir_plan[i].adv, dir_plan[i].last, dir_plan[i].rssi,
                  dir_plan[i].typed, dir_plan[i].code);
    end

    // random phases under both register settings
    set_full_record(1'b1);
    send_payloads(4, 70);
    set_full_record(1'b0);
    send_payloads(4, 70);
    set_full_record(1'b1);
    send_payloads(4, 70);
    s_axis_tvalid <= 1'b0;

    // drain
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ble_adv_record_parser_top_tb passed");
    end else begin
      $display("ble_adv_record_parser_top_tb failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bleadv_pkg.sv
rtl/core/bleadv_parse.sv
rtl/core/ble_adv_record_parser_top.sv
tb/sv/ble_adv_record_parser_top_tb.sv
